@@ rtl/tmhq_pkg.sv @@
// Package for the timer min-heap queue: word types, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tmhq_pkg;
	localparam int unsigned HeapDepthDefault = 16;
	localparam int unsigned ExpW = 41;
	localparam int unsigned MaxPops = 16;

	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_CANCEL = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_NONE     = 2'd3;

	typedef struct packed {
		logic [1:0]  func;
		logic [39:0] now;
		logic [31:0] delay;
		logic [3:0]  cancel_id;
	} cmd_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] timer_id;
		logic       last;
	} res_t;

	// Result of the shared expiry comparator.
	typedef struct packed {
		logic a_lt_b;
		logic a_le_b;
	} cmp_t;
endpackage
`default_nettype wire

@@ rtl/tmhq_cmp.sv @@
// Shared expiry comparator used by the sift compares and the tick due check of the sequencer.
// Depends on tmhq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tmhq_cmp import tmhq_pkg::*; (
	input  wire logic [ExpW-1:0] a,
	input  wire logic [ExpW-1:0] b,
	output cmp_t                 res
);
	always_comb begin
		res.a_lt_b = a < b;
		res.a_le_b = a <= b;
	end
endmodule
`default_nettype wire

@@ rtl/timer_min_heap_queue.sv @@
// Top level of the timer min-heap queue: sequencer, heap and id memories.
// Depends on tmhq_pkg and tmhq_cmp.
`timescale 1ns / 1ps
`default_nettype none
// The block keeps up to HEAP_DEPTH timers in a binary min-heap keyed by expiry
// time. A command word is taken when start is high and busy is low; busy then
// stays high while the operation runs, and the final result word appears in the
// first cycle with busy low again. A word with the unused operation code is
// taken, changes nothing and produces no result, so busy stays low for it.
// Each result word is valid for exactly one cycle with done high, and the
// receiver cannot stall it. Add finds the lowest free id with a scan of one id
// per cycle, then sifts up, each level taking a load step and then a
// compare-and-swap step. Cancel moves the last entry into the freed slot and
// sifts it down, each level loading the children, picking one when there are
// two, and doing a compare-and-swap; when it did not move down it sifts up
// instead. Each pop by tick moves the last entry to the root and sifts it down
// the same way, and the popped word is shown after the tick has checked
// whether another timer is due.
// All time is spent in one shared comparator working through the heap memory
// one step at a time. Tick pops at most 16 timers; remaining due timers wait.
module timer_min_heap_queue import tmhq_pkg::*; #(
	parameter int unsigned HEAP_DEPTH = HeapDepthDefault
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t cmd,
	output logic      busy,
	output logic      done,
	output res_t      result
);
	localparam int unsigned PW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
	localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
	localparam int unsigned KW = $clog2(MaxPops + 1);

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_SCAN    = 13'b0000000000010,
		S_INS     = 13'b0000000000100,
		S_UPCMP   = 13'b0000000001000,
		S_UPSWP   = 13'b0000000010000,
		S_CANCEL  = 13'b0000000100000,
		S_MOVE    = 13'b0000001000000,
		S_DNL     = 13'b0000010000000,
		S_DNR     = 13'b0000100000000,
		S_DNSWP   = 13'b0001000000000,
		S_TICK    = 13'b0010000000000,
		S_POP     = 13'b0100000000000,
		S_EMIT    = 13'b1000000000000
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;
	logic [ExpW-1:0] exp_mem [HEAP_DEPTH];
	logic [PW-1:0]   own_mem [HEAP_DEPTH];
	logic [PW-1:0]   pos_mem [HEAP_DEPTH];
	logic [HEAP_DEPTH-1:0] in_use_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] id_q;       // id scan / current id
	logic [PW-1:0] i_q;        // current slot
	logic [PW-1:0] j_q;        // partner slot
	logic [ExpW-1:0] ei_q, ej_q;
	logic [PW-1:0] oi_q, oj_q;
	logic [CW-1:0] lim_q;      // sift-down limit
	logic          moved_q;
	logic          ticking_q;
	logic [KW-1:0] k_q;
	logic [PW-1:0] lc_q;
	logic [ExpW-1:0] el_q;
	logic [PW-1:0] ol_q;
	logic          pop_go;

	logic [ExpW-1:0] ca, cb;
	cmp_t cr;
	tmhq_cmp u_cmp (.a(ca), .b(cb), .res(cr));

	// Child index computed wide, then checked against the limit.
	logic [CW:0] left_w;
	assign left_w = (CW+1)'({i_q, 1'b1});

	always_comb begin
		ca = ei_q;
		cb = ej_q;
		unique case (state_q)
			S_UPCMP: begin
				ca = ei_q; cb = ej_q;
			end
			S_DNR: begin
				ca = el_q; cb = ej_q;
			end
			S_DNSWP: begin
				ca = ej_q; cb = ei_q;
			end
			S_TICK: begin
				ca = exp_mem[0]; cb = {1'b0, cmd_q.now};
			end
			default: begin
				ca = ei_q; cb = ej_q;
			end
		endcase
	end

	// Tick keeps popping while the root is due and the per-tick limit is not hit.
	assign pop_go = (count_q != '0) && (k_q < KW'(MaxPops)) && cr.a_le_b;

	assign busy = (state_q != S_IDLE);

	// A word is shown after the emit state, when a tick ends, and after a tick
	// examines the next timer following at least one pop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (state_q == S_EMIT) || ((state_q == S_TICK) && (!pop_go || k_q != '0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			in_use_q  <= '0;
			count_q   <= '0;
			ticking_q <= 1'b0;
			k_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						id_q  <= '0;
						k_q   <= '0;
						ticking_q <= 1'b0;
						if (cmd.func == FUNC_ADD) begin
							if (count_q >= CW'(HEAP_DEPTH)) begin
								result <= '{ST_FULL, 4'd0, 1'b1};
								state_q <= S_EMIT;
							end else begin
								state_q <= S_SCAN;
							end
						end else if (cmd.func == FUNC_CANCEL) begin
							state_q <= S_CANCEL;
						end else if (cmd.func == FUNC_TICK) begin
							state_q <= S_TICK;
						end
					end
				end
				S_SCAN: begin
					if (!in_use_q[id_q]) begin
						state_q <= S_INS;
					end else if (id_q == PW'(HEAP_DEPTH - 1)) begin
						result <= '{ST_FULL, 4'd0, 1'b1};
						state_q <= S_EMIT;
					end else begin
						id_q <= id_q + 1'b1;
					end
				end
				S_INS: begin
					exp_mem[count_q[PW-1:0]] <= {1'b0, cmd_q.now} + ExpW'(cmd_q.delay);
					own_mem[count_q[PW-1:0]] <= id_q;
					pos_mem[id_q] <= count_q[PW-1:0];
					in_use_q[id_q] <= 1'b1;
					count_q <= count_q + 1'b1;
					ei_q <= {1'b0, cmd_q.now} + ExpW'(cmd_q.delay);
					oi_q <= id_q;
					i_q  <= count_q[PW-1:0];
					result <= '{ST_OK, 4'(id_q), 1'b1};
					if (count_q == '0) state_q <= S_EMIT;
					else begin
						j_q <= PW'((count_q - 1'b1) >> 1);
						state_q <= S_UPSWP;
						moved_q <= 1'b0;
					end
				end
				S_UPSWP: begin
					// Load the parent for comparison.
					ej_q <= exp_mem[j_q];
					oj_q <= own_mem[j_q];
					state_q <= S_UPCMP;
				end
				S_UPCMP: begin
					if (cr.a_lt_b) begin
						exp_mem[j_q] <= ei_q; own_mem[j_q] <= oi_q; pos_mem[oi_q] <= j_q;
						exp_mem[i_q] <= ej_q; own_mem[i_q] <= oj_q; pos_mem[oj_q] <= i_q;
						i_q <= j_q;
						if (j_q == '0) state_q <= S_EMIT;
						else begin
							j_q <= (j_q - 1'b1) >> 1;
							state_q <= S_UPSWP;
						end
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_CANCEL: begin
					if (32'(cmd_q.cancel_id) >= HEAP_DEPTH || count_q == '0
						|| !in_use_q[PW'(cmd_q.cancel_id)]) begin
						result <= '{ST_NOTFOUND, cmd_q.cancel_id, 1'b1};
						state_q <= S_EMIT;
					end else begin
						result <= '{ST_OK, cmd_q.cancel_id, 1'b1};
						in_use_q[PW'(cmd_q.cancel_id)] <= 1'b0;
						count_q <= count_q - 1'b1;
						lim_q <= count_q - 1'b1;
						i_q <= (CW'(pos_mem[PW'(cmd_q.cancel_id)]) > count_q - 1'b1)
							? PW'(count_q - 1'b1) : pos_mem[PW'(cmd_q.cancel_id)];
						state_q <= S_MOVE;
					end
				end
				S_MOVE: begin
					// Move the last entry into slot i, then sift it down.
					if (CW'(i_q) == lim_q) begin
						state_q <= ticking_q ? S_TICK : S_EMIT;
					end else begin
						exp_mem[i_q] <= exp_mem[lim_q[PW-1:0]];
						own_mem[i_q] <= own_mem[lim_q[PW-1:0]];
						pos_mem[own_mem[lim_q[PW-1:0]]] <= i_q;
						ei_q <= exp_mem[lim_q[PW-1:0]];
						oi_q <= own_mem[lim_q[PW-1:0]];
						moved_q <= 1'b0;
						state_q <= S_DNL;
					end
				end
				S_DNL: begin
					if (left_w >= (CW+1)'(lim_q)) begin
						// No child: sift down ends; cancel falls back to sift up.
						if (!moved_q && !ticking_q && i_q != '0) begin
							j_q <= (i_q - 1'b1) >> 1;
							state_q <= S_UPSWP;
						end else begin
							state_q <= ticking_q ? S_TICK : S_EMIT;
						end
					end else begin
						lc_q <= PW'(left_w);
						el_q <= exp_mem[PW'(left_w)];
						ol_q <= own_mem[PW'(left_w)];
						if ((left_w + 1'b1) < (CW+1)'(lim_q)) begin
							ej_q <= exp_mem[PW'(left_w + 1'b1)];
							oj_q <= own_mem[PW'(left_w + 1'b1)];
							j_q  <= PW'(left_w + 1'b1);
							state_q <= S_DNR;
						end else begin
							j_q  <= PW'(left_w);
							ej_q <= exp_mem[PW'(left_w)];
							oj_q <= own_mem[PW'(left_w)];
							state_q <= S_DNSWP;
						end
					end
				end
				S_DNR: begin
					// Right child wins ties; left wins only when strictly less.
					if (cr.a_lt_b) begin
						j_q <= lc_q; ej_q <= el_q; oj_q <= ol_q;
					end
					state_q <= S_DNSWP;
				end
				S_DNSWP: begin
					if (cr.a_lt_b) begin
						exp_mem[i_q] <= ej_q; own_mem[i_q] <= oj_q; pos_mem[oj_q] <= i_q;
						exp_mem[j_q] <= ei_q; own_mem[j_q] <= oi_q; pos_mem[oi_q] <= j_q;
						i_q <= j_q;
						moved_q <= 1'b1;
						state_q <= S_DNL;
					end else if (!moved_q && !ticking_q && i_q != '0) begin
						j_q <= (i_q - 1'b1) >> 1;
						state_q <= S_UPSWP;
					end else begin
						state_q <= ticking_q ? S_TICK : S_EMIT;
					end
				end
				S_TICK: begin
					// The previous popped word is held back so last can still be set;
					// it is shown in the next cycle, with last set when no other timer is due.
					if (pop_go) begin
						oi_q <= own_mem[0];
						state_q <= S_POP;
					end else begin
						ticking_q <= 1'b0;
						if (k_q == '0) begin
							result <= '{ST_NONE, 4'd0, 1'b1};
						end else begin
							result.last <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_POP: begin
					result <= '{ST_OK, 4'(oi_q), 1'b0};
					in_use_q[oi_q] <= 1'b0;
					count_q <= count_q - 1'b1;
					lim_q <= count_q - 1'b1;
					k_q <= k_q + 1'b1;
					i_q <= '0;
					ticking_q <= 1'b1;
					state_q <= S_MOVE;
				end
				S_EMIT: begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HEAP_DEPTH)) else $error("heap count overflow");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.func == FUNC_ADD || cmd.func == FUNC_CANCEL
		|| cmd.func == FUNC_TICK) |=> busy) else $error("accepted word did not raise busy");
	a_pop_limit: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= KW'(MaxPops)) else $error("too many pops");
`endif
endmodule
`default_nettype wire

@@ dv/timer_min_heap_queue_checker.sv @@
// Checker for the timer min-heap queue: watches command and result words,
// predicts each result from its own heap model and compares. Depends on tmhq_pkg.
`timescale 1ns / 1ps
module timer_min_heap_queue_checker import tmhq_pkg::*; #(
	parameter int unsigned DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  cmd_t        cmd,
	input  logic        done,
	input  res_t        result,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned results_seen
);
	logic [40:0] exp_key [DEPTH];
	logic [3:0]  owner [DEPTH];
	int unsigned pos_of [DEPTH];
	bit          in_use [DEPTH];
	int unsigned count;
	res_t        due_words [$];

	task automatic report(input string what, input res_t got, input res_t want);
		fail_count++;
		$display("MISMATCH %s: got st=%0d id=%0d last=%0d, want st=%0d id=%0d last=%0d",
			what, got.status, got.timer_id, got.last,
			want.status, want.timer_id, want.last);
	endtask

	function automatic void swap_slots(int unsigned a, int unsigned b);
		logic [40:0] k;
		logic [3:0]  o;
		k = exp_key[a]; o = owner[a];
		exp_key[a] = exp_key[b]; owner[a] = owner[b];
		exp_key[b] = k; owner[b] = o;
		pos_of[owner[a]] = a;
		pos_of[owner[b]] = b;
	endfunction

	function automatic bit sink(int unsigned from, int unsigned n);
		int unsigned i, l, pick;
		i = from;
		forever begin
			l = 2 * i + 1;
			if (l >= n) break;
			pick = l;
			// Equal children favor the right one.
			if (l + 1 < n && !(exp_key[l] < exp_key[l + 1])) pick = l + 1;
			if (!(exp_key[pick] < exp_key[i])) break;
			swap_slots(i, pick);
			i = pick;
		end
		return i > from;
	endfunction

	function automatic void rise(int unsigned j);
		int unsigned p;
		while (j > 0) begin
			p = (j - 1) / 2;
			if (!(exp_key[j] < exp_key[p])) break;
			swap_slots(p, j);
			j = p;
		end
	endfunction

	function automatic void push_word(logic [1:0] st, logic [3:0] id, logic lst);
		res_t r;
		r.status = st; r.timer_id = id; r.last = lst;
		due_words = {due_words, r};
	endfunction

	function automatic void predict(cmd_t c);
		int unsigned id, n, i, k;
		case (c.func)
			FUNC_ADD: begin
				id = 0;
				while (id < DEPTH && in_use[id]) id++;
				if (count >= DEPTH || id >= DEPTH) push_word(ST_FULL, 4'd0, 1'b1);
				else begin
					exp_key[count] = {1'b0, c.now} + {9'd0, c.delay};
					owner[count] = id[3:0];
					pos_of[id] = count;
					in_use[id] = 1;
					count++;
					rise(count - 1);
					push_word(ST_OK, id[3:0], 1'b1);
				end
			end
			FUNC_CANCEL: begin
				if (32'(c.cancel_id) >= DEPTH || !in_use[c.cancel_id] || count == 0)
					push_word(ST_NOTFOUND, c.cancel_id, 1'b1);
				else begin
					n = count - 1;
					i = pos_of[c.cancel_id];
					if (i > n) i = n;
					if (i != n) begin
						swap_slots(i, n);
						if (!sink(i, n)) rise(i);
					end
					count = n;
					in_use[c.cancel_id] = 0;
					push_word(ST_OK, c.cancel_id, 1'b1);
				end
			end
			FUNC_TICK: begin
				k = 0;
				while (count > 0 && k < MaxPops && exp_key[0] <= {1'b0, c.now}) begin
					id = owner[0];
					n = count - 1;
					if (n != 0) begin
						swap_slots(0, n);
						void'(sink(0, n));
					end
					count = n;
					in_use[id] = 0;
					push_word(ST_OK, id[3:0], 1'b0);
					k++;
				end
				if (k == 0) push_word(ST_NONE, 4'd0, 1'b1);
				else due_words[$].last = 1'b1;
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count = 0;
			results_seen <= 0;
			pending <= 0;
			count = 0;
			for (int q = 0; q < DEPTH; q++) in_use[q] = 0;
			due_words.delete();
		end else begin
			// Results come first: a new command cannot produce a word in the same cycle.
			if (done) begin
				results_seen <= results_seen + 1;
				if (due_words.size() == 0) begin
					report("unexpected result word", result, res_t'('0));
				end else begin
					res_t want;
					want = due_words.pop_front();
					if (result.status !== want.status) report("status", result, want);
					else if (result.timer_id !== want.timer_id) report("timer_id", result, want);
					else if (result.last !== want.last) report("last", result, want);
				end
			end
			if (start && !busy) predict(cmd);
			pending <= due_words.size();
		end
	end
endmodule

@@ dv/timer_min_heap_queue_test.sv @@
// Testbench top for the timer min-heap queue: directed and random command words,
// bursty sending, verdict. Depends on tmhq_pkg, the block and its checker.
`timescale 1ns / 1ps
module timer_min_heap_queue_test;
	import tmhq_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	cmd_t        cmd;
	logic        busy;
	logic        done;
	res_t        result;
	int unsigned fail_count, pending, results_seen;
	int unsigned idle_cycles;
	int unsigned words_sent;
	// The sender's own notion of time only moves forward, like a real clock.
	logic [39:0] clock_now;

	// No-progress limit: the longest stretch without an accepted word or a result
	// word is a single add, cancel or pop, or the longest random gap; the limit
	// is far above either.
	localparam int unsigned IdleLimit = 20000;

	timer_min_heap_queue dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .done(done), .result(result)
	);

	timer_min_heap_queue_checker #(.DEPTH(16)) chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .fail_count(fail_count),
		.pending(pending), .results_seen(results_seen)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// The watchdog counts cycles in which neither a command nor a result is taken.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("watchdog: no progress for %0d cycles", IdleLimit);
			$display("timer_min_heap_queue test failed");
			$finish;
		end
	end

	// Present one command word and hold it until the block takes it.
	task automatic send_word(input logic [1:0] f, input logic [39:0] t,
		input logic [31:0] d, input logic [3:0] id);
		start <= 1'b1;
		cmd <= '{func: f, now: t, delay: d, cancel_id: id};
		@(posedge clk);
		while (busy) @(posedge clk);
		words_sent++;
	endtask

	task automatic pause(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain;
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	// Pick a random operation mix: mostly adds and ticks, some cancels and a few unused-code words.
	// Cancels aim at random ids, live or not.
	task automatic random_word;
		int unsigned r;
		logic [31:0] d;
		r = $urandom_range(99);
		case ($urandom_range(3))
			0: d = $urandom_range(40);
			1: d = $urandom_range(400);
			2: d = 32'hFFFF_FFFF - $urandom_range(3);
			default: d = $urandom;
		endcase
		if ($urandom_range(3) == 0) clock_now = clock_now + $urandom_range(200);
		if (r < 45) send_word(FUNC_ADD, clock_now, d, 4'($urandom));
		else if (r < 65) send_word(FUNC_CANCEL, clock_now, $urandom, 4'($urandom));
		else if (r < 95) send_word(FUNC_TICK, clock_now, $urandom, 4'($urandom));
		else send_word(FUNC_UNUSED, 40'({$urandom, $urandom} >> 24), $urandom,
			4'($urandom));
	endtask

	initial begin
		start = 0;
		cmd = '0;
		words_sent = 0;
		idle_cycles = 0;
		clock_now = 40'd1000;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: empty heap cases, the unused code, fill to full, ties,
		// a repeated cancel, extreme field values and a big tick.
		send_word(FUNC_TICK, 40'd0, 32'd0, 4'd0);
		send_word(FUNC_CANCEL, 40'd0, 32'd0, 4'd15);
		send_word(FUNC_UNUSED, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
		for (int k = 0; k < 16; k++)
			send_word(FUNC_ADD, 40'hFF_FFFF_FF00, (k % 3 == 0) ? 32'hFFFF_FFFF : 32'd5 * k, 4'd0);
		send_word(FUNC_ADD, 40'd0, 32'd0, 4'd0);
		send_word(FUNC_CANCEL, 40'd0, 32'd0, 4'd3);
		send_word(FUNC_CANCEL, 40'd0, 32'd0, 4'd3);
		send_word(FUNC_CANCEL, 40'd0, 32'd0, 4'd14);
		send_word(FUNC_TICK, 40'hFF_FFFF_FF3C, 32'd0, 4'd0);
		send_word(FUNC_TICK, 40'hFF_FFFF_FFFF, 32'd0, 4'd0);
		drain();

		// Random part: bursts of random length separated by random gaps,
		// with an early stretch of back-to-back words.
		for (int b = 0; words_sent < 255; b++) begin
			int unsigned len;
			len = $urandom_range(1, 12);
			for (int k = 0; k < len; k++) random_word();
			if (b == 6) drain();
			else if (b > 2) pause($urandom_range(1, 30));
		end

		drain();
		repeat (60) @(posedge clk);
		$display("Sent %0d command words (add, cancel, tick, unused code) and checked %0d results,",
			words_sent, results_seen);
		$display("including a full heap, equal expiries and ticks at the end of time.");
		if (fail_count == 0 && pending == 0) begin
			$display("timer_min_heap_queue test passed");
		end else begin
			$display("timer_min_heap_queue test failed");
		end
		$finish;
	end
endmodule
